/* hw/rtl/tcm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package tcm_pkg;

	localparam int CordicStepsDefault = 16;
	localparam int AtanLen = 24;
	localparam int AccelW = 17;
	localparam int TempW = 15;
	localparam int LuxW = 16;
	localparam int AngleW = 15;
	localparam int SpeedW = 21;
	localparam int TiltW = 14;
	localparam int ScaleW = 16;
	localparam int CfgIdxW = 3;
	localparam int CfgDataW = 21;
	localparam int SqW = 2 * AccelW;
	localparam int RadW = SqW + 16;
	localparam int RootW = RadW / 2;
	localparam int CordW = 28;
	localparam int ZW = 32;
	localparam int AngleMax = 9000;

	typedef enum logic [CfgIdxW-1:0] {
		REG_TILT_LIMIT   = 3'd0,
		REG_TEMP_LOW     = 3'd1,
		REG_TEMP_HIGH    = 3'd2,
		REG_LUX_LIMIT    = 3'd3,
		REG_SPEED_LIMIT  = 3'd4,
		REG_SPEED_OFFSET = 3'd5,
		REG_STEP_SCALE   = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic start;
	} unit_ctl_t;

	// arctangent of 2^-i, in 2^-16 of 0.01 degree
	function automatic logic signed [ZW-1:0] atan_entry(input logic [4:0] idx);
		logic signed [ZW-1:0] v;
		case (idx)
			5'd0: v = 32'sd294912000;
			5'd1: v = 32'sd174096719;
			5'd2: v = 32'sd91987925;
			5'd3: v = 32'sd46694507;
			5'd4: v = 32'sd23437865;
			5'd5: v = 32'sd11730358;
			5'd6: v = 32'sd5866610;
			5'd7: v = 32'sd2933484;
			5'd8: v = 32'sd1466764;
			5'd9: v = 32'sd733385;
			5'd10: v = 32'sd366693;
			5'd11: v = 32'sd183346;
			5'd12: v = 32'sd91673;
			5'd13: v = 32'sd45837;
			5'd14: v = 32'sd22918;
			5'd15: v = 32'sd11459;
			5'd16: v = 32'sd5730;
			5'd17: v = 32'sd2865;
			5'd18: v = 32'sd1432;
			5'd19: v = 32'sd716;
			5'd20: v = 32'sd358;
			5'd21: v = 32'sd179;
			5'd22: v = 32'sd90;
			5'd23: v = 32'sd45;
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/tcm_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
module tcm_isqrt (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire tcm_pkg::unit_ctl_t   ctl_in,
	input  wire [tcm_pkg::RadW-1:0]   radicand,
	output logic                      done,
	output logic [tcm_pkg::RootW-1:0] root
);
	import tcm_pkg::*;

	localparam int CntW = $clog2(RootW + 1);

	logic [RadW-1:0]   op_q;
	logic [RootW:0]    rem_q;
	logic [RootW-1:0]  root_q;
	logic [CntW-1:0]   cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [RootW+2:0]  rem_next;
	logic [RootW+2:0]  trial;
	logic [RootW+2:0]  diff;

	always_comb begin
		rem_next = {rem_q, op_q[RadW-1 -: 2]};
		trial    = {1'b0, root_q, 2'b01};
		diff     = rem_next - trial;
	end

	// one root bit per cycle, restoring
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CntW'(RootW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			op_q   <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			op_q <= {op_q[RadW-3:0], 2'b00};
			if (rem_next >= trial) begin
				rem_q  <= diff[RootW:0];
				root_q <= {root_q[RootW-2:0], 1'b1};
			end else begin
				rem_q  <= rem_next[RootW:0];
				root_q <= {root_q[RootW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule
`default_nettype wire

/* hw/rtl/tcm_cordic.sv */
`timescale 1ns / 1ps
`default_nettype none
module tcm_cordic #(
	parameter int CORDIC_STEPS = tcm_pkg::CordicStepsDefault
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire tcm_pkg::unit_ctl_t           ctl_in,
	input  wire [tcm_pkg::RootW-1:0]          mag,
	input  wire signed [tcm_pkg::AccelW:0]    num,
	output logic                              done,
	output logic signed [tcm_pkg::AngleW-1:0] angle
);
	import tcm_pkg::*;

	localparam int IterW = $clog2(CORDIC_STEPS);

	logic signed [CordW-1:0] x_q, y_q, dx, dy;
	logic signed [ZW-1:0]    z_q, zs;
	logic signed [15:0]      zr;
	logic [IterW-1:0]        i_q;
	logic                    busy_q, done_q, zero_q, neg_q, pos_q;

	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl_in.start) begin
				busy_q <= 1'b1;
				i_q    <= '0;
			end else if (busy_q) begin
				if (i_q == IterW'(CORDIC_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	// rotate towards y = 0, accumulate the angle
	always_ff @(posedge clk) begin
		if (ctl_in.start) begin
			x_q    <= CordW'(mag);
			y_q    <= CordW'(num) <<< 8;
			z_q    <= '0;
			zero_q <= (mag == '0);
			neg_q  <= num[AccelW];
			pos_q  <= !num[AccelW] && (num != '0);
		end else if (busy_q) begin
			if (!y_q[CordW-1]) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + atan_entry(5'(i_q));
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - atan_entry(5'(i_q));
			end
		end
	end

	always_comb begin
		zs = z_q + 32'sd32768;
		zr = zs[ZW-1:16];
		if (zero_q) begin
			if (pos_q)
				angle = AngleW'(AngleMax);
			else if (neg_q)
				angle = AngleW'(-AngleMax);
			else
				angle = '0;
		end else if (zr > 16'sd9000) begin
			angle = AngleW'(AngleMax);
		end else if (zr < -16'sd9000) begin
			angle = AngleW'(-AngleMax);
		end else begin
			angle = zr[AngleW-1:0];
		end
	end

	assign done = done_q;

endmodule
`default_nettype wire

/* hw/rtl/tilt_and_condition_monitor.sv */
`timescale 1ns / 1ps
`default_nettype none
// Tilt and condition monitor: each accepted item (three accelerations, a
// temperature and a light level) yields one result with pitch and roll in
// 0.01 degree, a saturated vertical speed, a per-item limit flag and a sticky
// ok flag that only reset restores. Both angles run through one sequencer that
// squares on a shared multiplier, takes a bit-serial square root and then an
// iterative CORDIC vectoring pass. The input is not ready while an item is in
// flight, including while it waits for the result register to be free, and is
// ready again the cycle after the result is loaded. Limit registers are written
// through cfg_we / cfg_index / cfg_data; the user must write them only while the
// block is idle, as the block itself does not enforce it.
module tilt_and_condition_monitor #(
	parameter int CORDIC_STEPS = tcm_pkg::CordicStepsDefault
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [tcm_pkg::CfgIdxW-1:0]         cfg_index,
	input  wire [tcm_pkg::CfgDataW-1:0]        cfg_data,
	input  wire                                in_valid,
	output logic                               in_ready,
	input  wire signed [tcm_pkg::AccelW-1:0]   accel_x,
	input  wire signed [tcm_pkg::AccelW-1:0]   accel_y,
	input  wire signed [tcm_pkg::AccelW-1:0]   accel_z,
	input  wire signed [tcm_pkg::TempW-1:0]    temp_in,
	input  wire [tcm_pkg::LuxW-1:0]            light_lux,
	output logic                               out_valid,
	input  wire                                out_ready,
	output logic signed [tcm_pkg::AngleW-1:0]  pitch,
	output logic signed [tcm_pkg::AngleW-1:0]  roll,
	output logic signed [tcm_pkg::SpeedW-1:0]  speed_z,
	output logic                               sample_bad,
	output logic                               package_ok
);
	import tcm_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_SQA, S_SQB, S_ROOT, S_ROT, S_SPD, S_OUT
	} state_t;

	state_t state_q;

	logic [TiltW-1:0]         tilt_limit_q;
	logic signed [TempW-1:0]  temp_low_q, temp_high_q;
	logic [LuxW-1:0]          lux_limit_q;
	logic signed [SpeedW-1:0] speed_limit_q;
	logic [ScaleW-1:0]        speed_offset_q, step_scale_q;

	logic signed [AccelW-1:0] ax_q, ay_q, az_q, pz_q;
	logic signed [TempW-1:0]  temp_q;
	logic [LuxW-1:0]          lux_q;
	logic                     sel_q, ok_q;
	logic [SqW-1:0]           sq_q;
	logic signed [AngleW-1:0] pitch_q, roll_q;
	logic signed [34:0]       prod_q;

	logic signed [AccelW-1:0] mul_op;
	logic signed [SqW-1:0]    sqr;
	logic signed [AccelW:0]   num;
	logic [RootW-1:0]         root;
	logic signed [AngleW-1:0] angle;
	unit_ctl_t                sq_ctl, cd_ctl;
	logic                     sq_done, cd_done;

	logic signed [25:0]       sh;
	logic signed [26:0]       spd_full;
	logic signed [SpeedW-1:0] spd_sat;
	logic signed [15:0]       tl_s, p_s, r_s;
	logic                     bad, out_fire;

	// shared squarer: first term, then the z term for both angles
	assign mul_op = (state_q == S_SQA) ? (sel_q ? ay_q : ax_q) : az_q;
	assign sqr    = mul_op * mul_op;
	assign num    = sel_q ? -(AccelW + 1)'(ax_q) : (AccelW + 1)'(ay_q);

	assign sq_ctl.start = (state_q == S_SQB);
	assign cd_ctl.start = (state_q == S_ROOT) && sq_done;

	tcm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl_in   (sq_ctl),
		.radicand ({sq_q + $unsigned(sqr), 16'b0}),
		.done     (sq_done),
		.root     (root)
	);

	tcm_cordic #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl_in (cd_ctl),
		.mag    (root),
		.num    (num),
		.done   (cd_done),
		.angle  (angle)
	);

	always_comb begin
		sh       = 26'(prod_q >>> 9);
		spd_full = 27'(sh) - $signed({11'b0, speed_offset_q});
		if (spd_full > 27'sd1048575)
			spd_sat = SpeedW'(1048575);
		else if (spd_full < -27'sd1048576)
			spd_sat = SpeedW'(-1048576);
		else
			spd_sat = spd_full[SpeedW-1:0];
		tl_s = $signed({2'b0, tilt_limit_q});
		p_s  = 16'(pitch_q);
		r_s  = 16'(roll_q);
		bad  = (p_s > tl_s) || (p_s < -tl_s) || (r_s > tl_s) || (r_s < -tl_s)
			|| (temp_q < temp_low_q) || (temp_q > temp_high_q)
			|| (lux_q > lux_limit_q) || (spd_sat > speed_limit_q);
	end

	assign out_fire = (state_q == S_OUT) && (!out_valid || out_ready);
	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tilt_limit_q   <= TiltW'(4500);
			temp_low_q     <= TempW'(500);
			temp_high_q    <= TempW'(2500);
			lux_limit_q    <= LuxW'(100);
			speed_limit_q  <= SpeedW'(2560);
			speed_offset_q <= ScaleW'(2202);
			step_scale_q   <= ScaleW'(256);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TILT_LIMIT:   tilt_limit_q   <= cfg_data[TiltW-1:0];
				REG_TEMP_LOW:     temp_low_q     <= cfg_data[TempW-1:0];
				REG_TEMP_HIGH:    temp_high_q    <= cfg_data[TempW-1:0];
				REG_LUX_LIMIT:    lux_limit_q    <= cfg_data[LuxW-1:0];
				REG_SPEED_LIMIT:  speed_limit_q  <= cfg_data[SpeedW-1:0];
				REG_SPEED_OFFSET: speed_offset_q <= cfg_data[ScaleW-1:0];
				REG_STEP_SCALE:   step_scale_q   <= cfg_data[ScaleW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			sel_q      <= 1'b0;
			ok_q       <= 1'b1;
			pz_q       <= '0;
			out_valid  <= 1'b0;
			sample_bad <= 1'b0;
			package_ok <= 1'b1;
		end else begin
			if (out_valid && out_ready && !out_fire)
				out_valid <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						sel_q   <= 1'b0;
						state_q <= S_SQA;
					end
				end
				S_SQA:  state_q <= S_SQB;
				S_SQB:  state_q <= S_ROOT;
				S_ROOT: begin
					if (sq_done)
						state_q <= S_ROT;
				end
				S_ROT: begin
					if (cd_done) begin
						sel_q   <= 1'b1;
						state_q <= sel_q ? S_SPD : S_SQA;
					end
				end
				S_SPD:  state_q <= S_OUT;
				S_OUT: begin
					// hold until the result slot is free
					if (out_fire) begin
						out_valid  <= 1'b1;
						sample_bad <= bad;
						package_ok <= ok_q & ~bad;
						ok_q       <= ok_q & ~bad;
						pz_q       <= az_q;
						state_q    <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			ax_q   <= accel_x;
			ay_q   <= accel_y;
			az_q   <= accel_z;
			temp_q <= temp_in;
			lux_q  <= light_lux;
		end
		if (state_q == S_SQA)
			sq_q <= $unsigned(sqr);
		if (state_q == S_ROT && cd_done) begin
			if (sel_q)
				roll_q <= angle;
			else
				pitch_q <= angle;
		end
		if (state_q == S_SPD)
			prod_q <= (18'(az_q) + 18'(pz_q)) * $signed({1'b0, step_scale_q});
		if (out_fire) begin
			pitch   <= pitch_q;
			roll    <= roll_q;
			speed_z <= spd_sat;
		end
	end

endmodule
`default_nettype wire
